/* src/msdu_pkg.sv */
// Shared constants and types for the multi-channel smoothing debouncer.
package msdu_pkg;

   localparam int CHANNELS_DEF      = 16;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int MAX_LIVE          = 16;
   localparam int PIN_W             = 16;
   localparam int EN_W              = 16;
   localparam int CFG_W             = 17;
   localparam int CH_W              = 4;

   localparam logic [CFG_W-1:0] DECAY_RST = 17'd1966;

   typedef enum logic [1:0] {
      CSR_DECAY    = 2'd0,
      CSR_ACTIVATE = 2'd1,
      CSR_RELEASE  = 2'd2,
      CSR_ENABLE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic update;
   } lane_cmd_type;

endpackage

/* src/multi_channel_smoothing_debouncer_unit.sv */
// Top level of the multi-channel smoothing debouncer with hysteresis.
// Flow: a request accepted at edge t has its products registered at that same edge, updates
// the channel state at the first later edge where no events of an earlier request are pending,
// and its first event moves into the output register once that register is free.
// A new request is refused until the last has updated the state; an update waits for earlier
// events to leave; with rsp_ready high, one event per cycle leaves the single output register.
// Reset: synchronous; all levels to 1.0, all channels inactive, registers to defaults.
module multi_channel_smoothing_debouncer_unit #(
   parameter int CHANNELS      = msdu_pkg::CHANNELS_DEF,
   parameter int FRACTION_BITS = msdu_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [msdu_pkg::PIN_W-1:0]    req_pin_levels,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msdu_pkg::CH_W-1:0]     rsp_channel,
   output logic                          rsp_now_active,
   output logic                          rsp_last_event,
   input  logic                          csr_we,
   input  msdu_pkg::csr_index_type       csr_index,
   input  logic [msdu_pkg::CFG_W-1:0]    csr_wdata
);
   import msdu_pkg::*;

   localparam int LIVE    = (CHANNELS < MAX_LIVE) ? CHANNELS : MAX_LIVE;
   localparam int LEVEL_W = FRACTION_BITS + 1;
   localparam int CMP_W   = (LEVEL_W > CFG_W) ? LEVEL_W : CFG_W;
   localparam longint unsigned ONE_VAL = 64'd1 << FRACTION_BITS;
   localparam logic [LEVEL_W-1:0] ONE = LEVEL_W'(1) << FRACTION_BITS;
   localparam logic [CMP_W-1:0] ACT_RST = CMP_W'(ONE_VAL / 2);
   localparam logic [CMP_W-1:0] REL_RST = CMP_W'((ONE_VAL * 9) / 10);

   logic [CFG_W-1:0]   decay_ff, decay_in;
   logic [CMP_W-1:0]   act_ff, act_in;
   logic [CMP_W-1:0]   rel_ff, rel_in;
   logic [EN_W-1:0]    enable_ff, enable_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [CMP_W-1:0]   decay_ext;
   logic [LEVEL_W-1:0] decay_sat;
   logic               accept;
   logic               update;
   logic               merge_idle;
   lane_cmd_type       cmd;
   logic [LIVE-1:0]    evt_mask;
   logic [LIVE-1:0]    act_mask;

   always_comb begin
      decay_in  = decay_ff;
      act_in    = act_ff;
      rel_in    = rel_ff;
      enable_in = enable_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DECAY:    decay_in  = csr_wdata;
            CSR_ACTIVATE: act_in    = CMP_W'(csr_wdata);
            CSR_RELEASE:  rel_in    = CMP_W'(csr_wdata);
            CSR_ENABLE:   enable_in = csr_wdata[EN_W-1:0];
            default:      decay_in  = decay_ff;
         endcase
      end
   end

   assign decay_ext = CMP_W'(decay_ff);
   assign decay_sat = (decay_ext > CMP_W'(ONE)) ? ONE : decay_ext[LEVEL_W-1:0];

   assign req_ready   = !s1_valid_ff;
   assign accept      = req_valid && req_ready;
   assign update      = s1_valid_ff && merge_idle;
   assign cmd.capture = accept;
   assign cmd.update  = update;
   assign s1_valid_in = accept || (s1_valid_ff && !update);

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff    <= DECAY_RST;
         act_ff      <= ACT_RST;
         rel_ff      <= REL_RST;
         enable_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         decay_ff    <= decay_in;
         act_ff      <= act_in;
         rel_ff      <= rel_in;
         enable_ff   <= enable_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   for (genvar i = 0; i < LIVE; i++) begin : g_lane
      msdu_lane #(
         .FRACTION_BITS(FRACTION_BITS),
         .CMP_W        (CMP_W)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .enable     (enable_ff[i]),
         .pin        (req_pin_levels[i]),
         .decay      (decay_sat),
         .act_thr    (act_ff),
         .rel_thr    (rel_ff),
         .lane_event (evt_mask[i]),
         .lane_active(act_mask[i])
      );
   end

   msdu_merge #(
      .LANES(LIVE)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (update),
      .evt_mask      (evt_mask),
      .act_mask      (act_mask),
      .idle          (merge_idle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_channel   (rsp_channel),
      .rsp_now_active(rsp_now_active),
      .rsp_last_event(rsp_last_event)
   );

endmodule

/* src/msdu_lane.sv */
// One channel lane: smoothing multiply stage and level, hysteresis state update.
module msdu_lane #(
   parameter int FRACTION_BITS = 16,
   parameter int CMP_W         = 17
) (
   input  logic                         clock,
   input  logic                         reset,
   input  msdu_pkg::lane_cmd_type       cmd,
   input  logic                         enable,
   input  logic                         pin,
   input  logic [FRACTION_BITS:0]       decay,
   input  logic [CMP_W-1:0]             act_thr,
   input  logic [CMP_W-1:0]             rel_thr,
   output logic                         lane_event,
   output logic                         lane_active
);
   import msdu_pkg::*;

   localparam int LEVEL_W = FRACTION_BITS + 1;
   localparam int PROD_W  = 2 * LEVEL_W;
   localparam int SUM_W   = LEVEL_W + 1;
   localparam logic [LEVEL_W-1:0] ONE = LEVEL_W'(1) << FRACTION_BITS;

   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               trig_ff, trig_in;
   logic [LEVEL_W-1:0] q_ff, q_in;
   logic               pin_ff, pin_in;
   logic [PROD_W-1:0]  prod;
   logic [SUM_W-1:0]   sum;
   logic [LEVEL_W-1:0] lvl;
   logic [CMP_W-1:0]   lvl_c;

   assign prod = {{LEVEL_W{1'b0}}, level_ff} * {{LEVEL_W{1'b0}}, decay};

   always_comb begin
      q_in   = q_ff;
      pin_in = pin_ff;
      if (cmd.capture) begin
         q_in   = prod[FRACTION_BITS +: LEVEL_W];
         pin_in = pin;
      end
   end

   assign sum   = {1'b0, level_ff} - {1'b0, q_ff} + (pin_ff ? {1'b0, decay} : SUM_W'(0));
   assign lvl   = (sum > {1'b0, ONE}) ? ONE : sum[LEVEL_W-1:0];
   assign lvl_c = CMP_W'(lvl);

   always_comb begin
      level_in   = level_ff;
      trig_in    = trig_ff;
      lane_event = 1'b0;
      if (cmd.update) begin
         if (!enable) begin
            level_in = ONE;
            trig_in  = 1'b0;
         end else begin
            level_in = lvl;
            if (!trig_ff && (lvl_c < act_thr)) begin
               trig_in    = 1'b1;
               lane_event = 1'b1;
            end else if (trig_ff && (lvl_c > rel_thr)) begin
               trig_in    = 1'b0;
               lane_event = 1'b1;
            end
         end
      end
   end

   assign lane_active = trig_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= ONE;
         trig_ff  <= 1'b0;
      end else begin
         level_ff <= level_in;
         trig_ff  <= trig_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      pin_ff <= pin_in;
   end

endmodule

/* src/msdu_merge.sv */
// Event merger: holds the transition mask of one tick and emits events in channel order.
module msdu_merge #(
   parameter int LANES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [LANES-1:0]            evt_mask,
   input  logic [LANES-1:0]            act_mask,
   output logic                        idle,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [msdu_pkg::CH_W-1:0]   rsp_channel,
   output logic                        rsp_now_active,
   output logic                        rsp_last_event
);
   import msdu_pkg::*;

   logic [LANES-1:0] pend_ff, pend_in;
   logic [LANES-1:0] act_ff, act_in;
   logic             valid_ff, valid_in;
   logic [CH_W-1:0]  chan_ff, chan_in;
   logic             now_ff, now_in;
   logic             last_ff, last_in;
   logic [LANES-1:0] lowest;
   logic [LANES-1:0] rest;
   logic [CH_W-1:0]  sel;
   logic             slot_free;
   logic             pop;

   always_comb begin
      lowest = '0;
      sel    = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            lowest = LANES'(1) << i;
            sel    = CH_W'(i);
         end
      end
   end

   assign rest      = pend_ff & ~lowest;
   assign slot_free = !valid_ff || rsp_ready;
   assign pop       = slot_free && (pend_ff != '0);
   assign idle      = (pend_ff == '0);

   always_comb begin
      pend_in  = pend_ff;
      act_in   = act_ff;
      valid_in = valid_ff && !rsp_ready;
      chan_in  = chan_ff;
      now_in   = now_ff;
      last_in  = last_ff;
      if (load) begin
         pend_in = evt_mask;
         act_in  = act_mask;
      end else if (pop) begin
         pend_in  = rest;
         valid_in = 1'b1;
         chan_in  = sel;
         now_in   = |(lowest & act_ff);
         last_in  = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      chan_ff <= chan_in;
      now_ff  <= now_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_channel    = chan_ff;
   assign rsp_now_active = now_ff;
   assign rsp_last_event = last_ff;

   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> (pend_ff == '0))
      else $error("event mask loaded over pending events");

   a_events_kept: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |=> ((pend_ff != '0) || valid_ff))
      else $error("pending events vanished");

   a_pop_one: assert property (@(posedge clock) disable iff (reset)
      pop |=> ($countones(pend_ff) == $countones($past(pend_ff)) - 1))
      else $error("pop did not retire exactly one event");

endmodule
